/* design/bst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

    localparam int MAX_MESSAGE_DEFAULT = 65536;
    localparam int KEYWORD_LEN_DEFAULT = 8;

    // letters of the longest keyword; the matcher looks at no more
    localparam int KW_MAX   = 8;
    localparam int KW_COUNT = 11;

    localparam logic [4:0] KIND_NONE     = 5'd0;
    localparam logic [4:0] KIND_NEWLINE  = 5'd0;
    localparam logic [4:0] KIND_NUMBER   = 5'd1;
    localparam logic [4:0] KIND_IDENT    = 5'd2;
    localparam logic [4:0] KIND_STRING   = 5'd3;
    localparam logic [4:0] KIND_KEY0     = 5'd4;
    localparam logic [4:0] KIND_EQ       = 5'd15;
    localparam logic [4:0] KIND_PLUS     = 5'd16;
    localparam logic [4:0] KIND_MINUS    = 5'd17;
    localparam logic [4:0] KIND_ASTERISK = 5'd18;
    localparam logic [4:0] KIND_SLASH    = 5'd19;
    localparam logic [4:0] KIND_EQEQ     = 5'd20;
    localparam logic [4:0] KIND_NOTEQ    = 5'd21;
    localparam logic [4:0] KIND_LT       = 5'd22;
    localparam logic [4:0] KIND_LTEQ     = 5'd23;
    localparam logic [4:0] KIND_GT       = 5'd24;
    localparam logic [4:0] KIND_GTEQ     = 5'd25;
    localparam logic [4:0] KIND_NOT      = 5'd26;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_UNTERM  = 2'd2;

    // pending operator codes
    localparam logic [1:0] PEND_BANG = 2'd0;
    localparam logic [1:0] PEND_EQ   = 2'd1;
    localparam logic [1:0] PEND_LT   = 2'd2;
    localparam logic [1:0] PEND_GT   = 2'd3;

    // keywords left-aligned, padded with spaces
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "LABEL   ", "GOTO    ", "PRINT   ", "INPUT   ", "LET     ", "IF      ",
        "THEN    ", "ENDIF   ", "WHILE   ", "REPEAT  ", "ENDWHILE"
    };
    localparam int KW_LEN [KW_COUNT] = '{5, 4, 5, 5, 3, 2, 4, 5, 5, 6, 8};

    typedef struct packed {
        logic        token_valid;
        logic [4:0]  token_kind;
        logic [15:0] start_pos;
        logic [15:0] token_len;
        logic [1:0]  status;
        logic        run_last;
        logic        message_end;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r1;
        result_t    r0;
    } emit_t;

    function automatic result_t make_result(input logic valid, input logic [4:0] kind,
                                            input logic [15:0] start, input logic [15:0] len,
                                            input logic [1:0] status);
        result_t r;
        r.token_valid = valid;
        r.token_kind  = kind;
        r.start_pos   = start;
        r.token_len   = len;
        r.status      = status;
        r.run_last    = 1'b0;
        r.message_end = 1'b0;
        return r;
    endfunction

    // append a result; a third one is dropped
    function automatic emit_t emit_push(input emit_t e, input result_t r);
        emit_t o;
        o = e;
        if (e.cnt == 2'd0)
        begin
            o.r0  = r;
            o.cnt = 2'd1;
        end
        else if (e.cnt == 2'd1)
        begin
            o.r1  = r;
            o.cnt = 2'd2;
        end
        return o;
    endfunction

    function automatic logic [4:0] op_single(input logic [1:0] pend);
        logic [4:0] k;
        case (pend)
            PEND_BANG: k = KIND_NOT;
            PEND_EQ:   k = KIND_EQ;
            PEND_LT:   k = KIND_LT;
            PEND_GT:   k = KIND_GT;
            default:   k = KIND_NOT;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] op_double(input logic [1:0] pend);
        logic [4:0] k;
        case (pend)
            PEND_BANG: k = KIND_NOTEQ;
            PEND_EQ:   k = KIND_EQEQ;
            PEND_LT:   k = KIND_LTEQ;
            PEND_GT:   k = KIND_GTEQ;
            default:   k = KIND_NOTEQ;
        endcase
        return k;
    endfunction

    // letters hold the low five bits of each upper-case character
    function automatic logic [4:0] word_kind(input logic [KW_MAX*5-1:0] letters,
                                             input logic [15:0] len, input logic possible);
        logic [4:0] kind;
        logic       same;
        kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            same = possible && (len == 16'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX; i++)
            begin
                if (i < KW_LEN[k])
                begin
                    same = same && (letters[i*5 +: 5] == KW_TEXT[k][(7-i)*8 +: 5]);
                end
            end
            if (same)
            begin
                kind = 5'(int'(KIND_KEY0) + k);
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

/* design/bst_char_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bst_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       message_last;

    modport source (output valid, output char_code, output message_last, input ready);
    modport sink   (input valid, input char_code, input message_last, output ready);
endinterface

`default_nettype wire

/* design/bst_token_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bst_token_if;
    logic        valid;
    logic        ready;
    logic        token_valid;
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_len;
    logic [1:0]  status;
    logic        run_last;
    logic        message_end;

    modport source (output valid, output token_valid, output token_kind, output start_pos,
                    output token_len, output status, output run_last, output message_end,
                    input ready);
    modport sink   (input valid, input token_valid, input token_kind, input start_pos,
                    input token_len, input status, input run_last, input message_end,
                    output ready);
endinterface

`default_nettype wire

/* design/basic_source_tokenizer.sv */
// Results of a character are registered in the result queue on its transfer.
// Throughput: one character per cycle while two or more queue slots are free;
// a character that closes one token and yields another puts two results in the
// four-entry result queue, which drains one per cycle while tokens.ready.
// Reset: rst_n asynchronous, clears lexer mode, positions and the queue;
// the keyword letter store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module basic_source_tokenizer
    import bst_pkg::*;
#(
    parameter int MAX_MESSAGE = MAX_MESSAGE_DEFAULT,
    parameter int KEYWORD_LEN = KEYWORD_LEN_DEFAULT
)
(
    input  wire          clk,
    input  wire          rst_n,
    bst_char_if.sink     chars,
    bst_token_if.source  tokens
);

    localparam int POS_W = $clog2(MAX_MESSAGE);
    localparam int IDX_W = $clog2(KEYWORD_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_MESSAGE - 1);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_NUMBER  = 3'd1;
    localparam logic [2:0] MODE_IDENT   = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_OPER    = 3'd4;
    localparam logic [2:0] MODE_DISCARD = 3'd5;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
        return (p == POS_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] len_inc(input logic [POS_W-1:0] l);
        return (l == POS_LAST) ? l : l + 1'b1;
    endfunction

    logic [2:0]       mode_reg, mode_next;
    logic [1:0]       pend_reg, pend_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic             poss_reg, poss_next;
    logic [4:0]       letters_reg [KEYWORD_LEN];
    logic [4:0]       letters_next [KEYWORD_LEN];

    result_t          queue_reg [4];
    logic [1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [2:0]       count_reg;

    logic [7:0]       c;
    logic             last;
    logic             is_digit, is_upper, is_letter, is_space;
    logic             do_idle;
    logic [15:0]      pos16;
    logic [KW_MAX*5-1:0] word_cur, word_new;
    emit_t            e;
    logic             accept, pop;

    assign c         = chars.char_code;
    assign last      = chars.message_last;
    assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
    assign is_upper  = (c >= 8'h41) && (c <= 8'h5A);
    assign is_letter = is_upper || ((c >= 8'h61) && (c <= 8'h7A));
    assign is_space  = (c == CH_SPACE) || (c == CH_FF) || (c == CH_CR) ||
                       (c == CH_TAB) || (c == CH_VT);
    assign pos16     = 16'(pos_reg);

    assign chars.ready = (count_reg <= 3'd2);
    assign accept      = chars.valid && chars.ready;
    assign pop         = tokens.valid && tokens.ready;

    always_comb
    begin
        for (int i = 0; i < KW_MAX; i++)
        begin
            word_cur[i*5 +: 5] = letters_reg[i];
        end
    end

    always_comb
    begin
        e            = '0;
        mode_next    = mode_reg;
        pend_next    = pend_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        poss_next    = poss_reg;
        letters_next = letters_reg;
        pos_next     = pos_reg;
        do_idle      = 1'b0;

        case (mode_reg)
            MODE_DISCARD:
            begin
                do_idle = 1'b0;
            end
            MODE_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    e = emit_push(e, make_result(1'b1, KIND_STRING, 16'(start_reg),
                                                 16'(len_reg), STATUS_OK));
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    len_next = len_inc(len_reg);
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    len_next = len_inc(len_reg);
                end
                else
                begin
                    e = emit_push(e, make_result(1'b1, KIND_NUMBER, 16'(start_reg),
                                                 16'(len_reg), STATUS_OK));
                    do_idle = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_letter)
                begin
                    if (poss_reg && is_upper && (len_reg < POS_W'(KEYWORD_LEN)))
                    begin
                        letters_next[len_reg[IDX_W-1:0]] = c[4:0];
                    end
                    else
                    begin
                        poss_next = 1'b0;
                    end
                    len_next = len_inc(len_reg);
                end
                else
                begin
                    e = emit_push(e, make_result(1'b1,
                                                 word_kind(word_cur, 16'(len_reg), poss_reg),
                                                 16'(start_reg), 16'(len_reg), STATUS_OK));
                    do_idle = 1'b1;
                end
            end
            MODE_OPER:
            begin
                mode_next = MODE_IDLE;
                if (c == CH_EQ)
                begin
                    e = emit_push(e, make_result(1'b1, op_double(pend_reg), 16'(start_reg),
                                                 16'd2, STATUS_OK));
                end
                else
                begin
                    e = emit_push(e, make_result(1'b1, op_single(pend_reg), 16'(start_reg),
                                                 16'd1, STATUS_OK));
                    do_idle = 1'b1;
                end
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        // character with no token open or ending a number, word or operator
        if (do_idle)
        begin
            mode_next = MODE_IDLE;
            if (is_space)
            begin
                mode_next = MODE_IDLE;
            end
            else if (c == CH_NL)
            begin
                e = emit_push(e, make_result(1'b1, KIND_NEWLINE, pos16, 16'd1, STATUS_OK));
            end
            else if (c == CH_PLUS)
            begin
                e = emit_push(e, make_result(1'b1, KIND_PLUS, pos16, 16'd1, STATUS_OK));
            end
            else if (c == CH_MINUS)
            begin
                e = emit_push(e, make_result(1'b1, KIND_MINUS, pos16, 16'd1, STATUS_OK));
            end
            else if (c == CH_STAR)
            begin
                e = emit_push(e, make_result(1'b1, KIND_ASTERISK, pos16, 16'd1, STATUS_OK));
            end
            else if (c == CH_SLASH)
            begin
                e = emit_push(e, make_result(1'b1, KIND_SLASH, pos16, 16'd1, STATUS_OK));
            end
            else if ((c == CH_BANG) || (c == CH_EQ) || (c == CH_LT) || (c == CH_GT))
            begin
                mode_next  = MODE_OPER;
                start_next = pos_reg;
                len_next   = POS_W'(1);
                if (c == CH_BANG)
                    pend_next = PEND_BANG;
                else if (c == CH_EQ)
                    pend_next = PEND_EQ;
                else if (c == CH_LT)
                    pend_next = PEND_LT;
                else
                    pend_next = PEND_GT;
            end
            else if (c == CH_QUOTE)
            begin
                mode_next  = MODE_STRING;
                start_next = pos_inc(pos_reg);
                len_next   = '0;
            end
            else if (is_digit)
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                len_next   = POS_W'(1);
            end
            else if (is_letter)
            begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                len_next   = POS_W'(1);
                poss_next  = is_upper;
                if (is_upper)
                begin
                    letters_next[0] = c[4:0];
                end
            end
            else
            begin
                e = emit_push(e, make_result(1'b0, KIND_NONE, pos16, 16'd1,
                                             STATUS_INVALID));
                mode_next = MODE_DISCARD;
            end
        end

        for (int i = 0; i < KW_MAX; i++)
        begin
            word_new[i*5 +: 5] = letters_next[i];
        end

        if (last)
        begin
            // flush any open token; an open string yields STATUS_UNTERM
            case (mode_next)
                MODE_NUMBER:
                begin
                    e = emit_push(e, make_result(1'b1, KIND_NUMBER, 16'(start_next),
                                                 16'(len_next), STATUS_OK));
                end
                MODE_IDENT:
                begin
                    e = emit_push(e, make_result(1'b1,
                                                 word_kind(word_new, 16'(len_next), poss_next),
                                                 16'(start_next), 16'(len_next), STATUS_OK));
                end
                MODE_OPER:
                begin
                    e = emit_push(e, make_result(1'b1, op_single(pend_next), 16'(start_next),
                                                 16'd1, STATUS_OK));
                end
                MODE_STRING:
                begin
                    e = emit_push(e, make_result(1'b0, KIND_NONE, 16'(start_next),
                                                 16'(len_next), STATUS_UNTERM));
                end
                default:
                begin
                    e = e;
                end
            endcase
            if (e.cnt == 2'd0)
            begin
                e = emit_push(e, make_result(1'b0, KIND_NONE, 16'd0, 16'd0, STATUS_OK));
            end
            if (e.cnt == 2'd1)
                e.r0.message_end = 1'b1;
            else
                e.r1.message_end = 1'b1;

            mode_next  = MODE_IDLE;
            pend_next  = PEND_BANG;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            poss_next  = 1'b0;
        end
        else
        begin
            pos_next = pos_inc(pos_reg);
        end

        if (e.cnt == 2'd1)
            e.r0.run_last = 1'b1;
        else if (e.cnt == 2'd2)
            e.r1.run_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= PEND_BANG;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            poss_reg   <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                pend_reg   <= pend_next;
                pos_reg    <= pos_next;
                start_reg  <= start_next;
                len_reg    <= len_next;
                poss_reg   <= poss_next;
                wr_ptr_reg <= wr_ptr_reg + e.cnt;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (accept ? {1'b0, e.cnt} : 3'd0) - {2'b00, pop};
        end
    end

    // letter store and result queue payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            letters_reg <= letters_next;
            if (e.cnt != 2'd0)
            begin
                queue_reg[wr_ptr_reg] <= e.r0;
            end
            if (e.cnt == 2'd2)
            begin
                queue_reg[wr_ptr_reg + 2'd1] <= e.r1;
            end
        end
    end

    assign tokens.valid       = (count_reg != 3'd0);
    assign tokens.token_valid = queue_reg[rd_ptr_reg].token_valid;
    assign tokens.token_kind  = queue_reg[rd_ptr_reg].token_kind;
    assign tokens.start_pos   = queue_reg[rd_ptr_reg].start_pos;
    assign tokens.token_len   = queue_reg[rd_ptr_reg].token_len;
    assign tokens.status      = queue_reg[rd_ptr_reg].status;
    assign tokens.run_last    = queue_reg[rd_ptr_reg].run_last;
    assign tokens.message_end = queue_reg[rd_ptr_reg].message_end;

endmodule

`default_nettype wire
